FILE: rtl/tsn_pkg.sv
// Shared types, codes and helper functions for the tangent-space normal transform.
package tsn_pkg;

  localparam int IDX_W = 20;
  localparam int POS_W = 32;
  localparam int UV_W  = 24;
  localparam int NRM_W = 16;
  localparam int TAN_W = 16;

  // Three corners of one face, as handed from the front to the back.
  typedef struct packed {
    logic [2:0][2:0][POS_W-1:0] pos;
    logic [2:0][1:0][UV_W-1:0]  uv;
    logic [2:0][2:0][NRM_W-1:0] nrm;
    logic [2:0][IDX_W-1:0]      idx;
    logic                       last;
  } face_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [TAN_W-1:0] tx;
    logic [TAN_W-1:0] ty;
    logic [TAN_W-1:0] tz;
    logic             degenerate;
    logic             last_of_face;
    logic             mesh_done;
  } result_t;

  typedef struct packed {
    logic done;
    logic ok;
  } norm_rsp_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIVINIT,
    N_DIV,
    N_DONE
  } norm_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIFF,
    B_MUL,
    B_ACC,
    B_WB,
    B_NORM,
    B_NWAIT,
    B_FLIP,
    B_EMIT,
    B_DEGEN
  } back_state_e;

  typedef enum logic [3:0] {
    J_DET,
    J_TP,
    J_BP,
    J_N,
    J_DOT,
    J_PERP,
    J_C,
    J_HD,
    J_PR
  } job_e;

  typedef enum logic [2:0] {
    NS_T,
    NS_B1,
    NS_N,
    NS_B2,
    NS_P
  } nsel_e;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // Shift a signed value right by 30, truncating its magnitude.
  function automatic logic [63:0] shr30(input logic [63:0] x);
    logic [63:0] m;
    m = mag64(x) >> 30;
    return x[63] ? (~m + 64'd1) : m;
  endfunction

endpackage

FILE: rtl/tsn_fifo.sv
// Small first-in first-out queue of one record type.
module tsn_fifo #(
  parameter type T_t   = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T_t   data_i,
  output logic full_o,
  input  logic pop_i,
  output T_t   data_o,
  output logic empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T_t            mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/tsn_norm.sv
// Iterative vector normalizer: shift search, square root and three divides.
module tsn_norm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0][63:0]      vec_i,
  output tsn_pkg::norm_rsp_t    rsp_o,
  output logic [2:0][63:0]      vec_o
);
  import tsn_pkg::*;

  norm_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  comp_q, comp_d;
  logic        ok_q, ok_d;

  logic [63:0] m_q [3];
  logic [2:0]  neg_q;
  logic [63:0] sum_q;
  logic [61:0] prod_q;
  logic [63:0] rn_q, root_q, bit_q;
  logic [32:0] rem_q;
  logic [30:0] num_q, dq_q;
  logic [30:0] q_q [3];

  logic [63:0] mx, m01;
  logic [63:0] root_try;
  logic        sq_take;
  logic [31:0] len;
  logic [61:0] dnum;
  logic [33:0] trial;
  logic        ge;
  logic [32:0] rem_next;

  assign m01      = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
  assign mx       = (m01 > m_q[2]) ? m01 : m_q[2];
  assign root_try = root_q + bit_q;
  assign sq_take  = (rn_q >= root_try);
  assign len      = root_q[31:0];
  assign dnum     = {1'b0, m_q[comp_q][30:0], 30'b0} + 62'(len[31:1]);
  assign trial    = {rem_q, num_q[30]};
  assign ge       = (trial >= {2'b00, len});
  assign rem_next = ge ? 33'(trial - {2'b00, len}) : trial[32:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      ok_q    <= ok_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    ok_d    = ok_q;
    case (state_q)
      N_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = N_SHIFT;
        end
      end
      N_SHIFT: begin
        if (mx == '0) begin
          ok_d    = 1'b0;
          state_d = N_DONE;
        end else if (!(|mx[63:31])) begin
          ok_d    = 1'b1;
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        if (cnt_q == 5'd3) begin
          cnt_d   = '0;
          state_d = N_SQRT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      N_SQRT: begin
        comp_d = '0;
        if (cnt_q == 5'd31) begin
          cnt_d   = '0;
          state_d = N_DIVINIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      N_DIVINIT: begin
        cnt_d   = '0;
        state_d = N_DIV;
      end
      N_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          if (comp_q == 2'd2) begin
            state_d = N_DONE;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = N_DIVINIT;
          end
        end
      end
      N_DONE: begin
        state_d = N_IDLE;
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            m_q[i]   <= mag64(vec_i[i]);
            neg_q[i] <= vec_i[i][63];
            q_q[i]   <= '0;
          end
        end
      end
      N_SHIFT: begin
        sum_q <= '0;
        if (|mx[63:31]) begin
          for (int i = 0; i < 3; i++) begin
            m_q[i] <= m_q[i] >> 1;
          end
        end
      end
      N_SQ: begin
        if (cnt_q != 5'd3) begin
          prod_q <= m_q[cnt_q[1:0]][30:0] * m_q[cnt_q[1:0]][30:0];
        end
        if (cnt_q != 5'd0) begin
          sum_q <= sum_q + 64'(prod_q);
        end
        if (cnt_q == 5'd3) begin
          rn_q   <= sum_q + 64'(prod_q);
          root_q <= '0;
          bit_q  <= 64'd1 << 62;
        end
      end
      N_SQRT: begin
        if (sq_take) begin
          rn_q   <= rn_q - root_try;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_DIVINIT: begin
        rem_q <= 33'(dnum[61:31]);
        num_q <= dnum[30:0];
        dq_q  <= '0;
      end
      N_DIV: begin
        rem_q <= rem_next;
        num_q <= num_q << 1;
        dq_q  <= {dq_q[29:0], ge};
        if (cnt_q == 5'd30) begin
          q_q[comp_q] <= {dq_q[29:0], ge};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec_o[i] = neg_q[i] ? (~64'(q_q[i]) + 64'd1) : 64'(q_q[i]);
    end
  end

  assign rsp_o.done = (state_q == N_DONE);
  assign rsp_o.ok   = ok_q;

endmodule

FILE: rtl/tsn_front.sv
// Front end: holds the first two corners of a face and queues whole faces.
module tsn_front #(
  parameter int INDEX_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [tsn_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [tsn_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [tsn_pkg::POS_W-1:0]    pos_z_i,
  input  logic signed [tsn_pkg::UV_W-1:0]     tex_u_i,
  input  logic signed [tsn_pkg::UV_W-1:0]     tex_v_i,
  input  logic signed [tsn_pkg::NRM_W-1:0]    normal_x_i,
  input  logic signed [tsn_pkg::NRM_W-1:0]    normal_y_i,
  input  logic signed [tsn_pkg::NRM_W-1:0]    normal_z_i,
  input  logic [tsn_pkg::IDX_W-1:0]           normal_index_i,
  input  logic                                mesh_end_i,
  input  logic                                face_full_i,
  output logic                                face_push_o,
  output tsn_pkg::face_t                      face_o
);
  import tsn_pkg::*;

  localparam int KEEP = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << KEEP) - 64'd1);

  logic [1:0]                        cnt_q;
  logic [1:0][2:0][POS_W-1:0]        hpos_q;
  logic [1:0][1:0][UV_W-1:0]         huv_q;
  logic [1:0][2:0][NRM_W-1:0]        hnrm_q;
  logic [1:0][IDX_W-1:0]             hidx_q;
  logic                              accept;
  logic [IDX_W-1:0]                  idx_in;

  assign full        = (cnt_q == 2'd2) && face_full_i;
  assign accept      = push && !full;
  assign face_push_o = accept && (cnt_q == 2'd2);
  assign idx_in      = normal_index_i & IDX_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q != 2'd2)) begin
      hpos_q[cnt_q[0]] <= {pos_z_i, pos_y_i, pos_x_i};
      huv_q[cnt_q[0]]  <= {tex_v_i, tex_u_i};
      hnrm_q[cnt_q[0]] <= {normal_z_i, normal_y_i, normal_x_i};
      hidx_q[cnt_q[0]] <= idx_in;
    end
  end

  always_comb begin
    face_o.pos  = {pos_z_i, pos_y_i, pos_x_i, hpos_q[1], hpos_q[0]};
    face_o.uv   = {tex_v_i, tex_u_i, huv_q[1], huv_q[0]};
    face_o.nrm  = {normal_z_i, normal_y_i, normal_x_i, hnrm_q[1], hnrm_q[0]};
    face_o.idx  = {idx_in, hidx_q[1], hidx_q[0]};
    face_o.last = mesh_end_i;
  end

endmodule

FILE: rtl/tsn_back.sv
// Back end: builds the face frame with a shared multiplier and emits three results.
module tsn_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 face_empty_i,
  input  tsn_pkg::face_t       face_i,
  output logic                 face_pop_o,
  output logic                 norm_start_o,
  output logic [2:0][63:0]     norm_vec_o,
  input  tsn_pkg::norm_rsp_t   norm_rsp_i,
  input  logic [2:0][63:0]     norm_res_i,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output tsn_pkg::result_t     res_o
);
  import tsn_pkg::*;

  back_state_e state_q, state_d;
  job_e        job_q, job_d;
  nsel_e       nsel_q, nsel_d;
  logic [1:0]  i_q, i_d, j_q, j_d, k_q, k_d;

  face_t              rec_q;
  logic signed [32:0] e1_q [3];
  logic signed [32:0] e2_q [3];
  logic signed [24:0] du1_q, dv1_q, du2_q, dv2_q;
  logic               det_neg_q;
  logic signed [63:0] t_q [3];
  logic signed [63:0] b_q [3];
  logic signed [63:0] n_q [3];
  logic signed [63:0] pr_q [3];
  logic signed [32:0] c_q [3];
  logic signed [32:0] d30_q;
  logic signed [63:0] acc_q, mul_q;
  logic               good_q;

  logic signed [32:0] op_a, op_b;
  logic               op_neg;
  logic signed [65:0] prod;
  logic [1:0]         nterms_m1, ncomp_m1;
  logic [63:0]        acc_shr;
  logic signed [63:0] acc_base;
  logic               emit_good;

  function automatic logic [1:0] nxt3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  function automatic logic [15:0] to_q14(input logic [63:0] x);
    logic [63:0] m;
    logic [15:0] r;
    m = mag64(x);
    r = 16'((m + 64'd32768) >> 16);
    return x[63] ? (~r + 16'd1) : r;
  endfunction

  assign acc_shr  = shr30(acc_q);
  assign acc_base = (j_q == 2'd0) ? 64'sd0 : acc_q;
  assign prod     = op_a * op_b;

  always_comb begin : operands
    logic [1:0] i1, i2;
    i1 = nxt3(i_q);
    i2 = nxt3(i1);
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    case (job_q)
      J_DET: begin
        if (j_q == 2'd0) begin
          op_a = 33'(du1_q);
          op_b = 33'(dv2_q);
        end else begin
          op_a   = 33'(du2_q);
          op_b   = 33'(dv1_q);
          op_neg = 1'b1;
        end
      end
      J_TP: begin
        if (j_q == 2'd0) begin
          op_a = e1_q[i_q];
          op_b = 33'(dv2_q);
        end else begin
          op_a   = e2_q[i_q];
          op_b   = 33'(dv1_q);
          op_neg = 1'b1;
        end
      end
      J_BP: begin
        if (j_q == 2'd0) begin
          op_a = e2_q[i_q];
          op_b = 33'(du1_q);
        end else begin
          op_a   = e1_q[i_q];
          op_b   = 33'(du2_q);
          op_neg = 1'b1;
        end
      end
      J_N: begin
        if (j_q == 2'd0) begin
          op_a = $signed(t_q[i1][32:0]);
          op_b = $signed(b_q[i2][32:0]);
        end else begin
          op_a   = $signed(t_q[i2][32:0]);
          op_b   = $signed(b_q[i1][32:0]);
          op_neg = 1'b1;
        end
      end
      J_DOT: begin
        op_a = $signed(t_q[j_q][32:0]);
        op_b = $signed(b_q[j_q][32:0]);
      end
      J_PERP: begin
        op_a = d30_q;
        op_b = $signed(t_q[i_q][32:0]);
      end
      J_C: begin
        if (j_q == 2'd0) begin
          op_a = $signed(n_q[i1][32:0]);
          op_b = $signed(t_q[i2][32:0]);
        end else begin
          op_a   = $signed(n_q[i2][32:0]);
          op_b   = $signed(t_q[i1][32:0]);
          op_neg = 1'b1;
        end
      end
      J_HD: begin
        op_a = c_q[j_q];
        op_b = $signed(b_q[j_q][32:0]);
      end
      J_PR: begin
        op_a = 33'($signed(rec_q.nrm[k_q][j_q]));
        case (i_q)
          2'd0:    op_b = $signed(t_q[j_q][32:0]);
          2'd1:    op_b = $signed(b_q[j_q][32:0]);
          default: op_b = $signed(n_q[j_q][32:0]);
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (job_q)
      J_PERP:               nterms_m1 = 2'd0;
      J_DOT, J_HD, J_PR:    nterms_m1 = 2'd2;
      default:              nterms_m1 = 2'd1;
    endcase
    case (job_q)
      J_DET, J_DOT, J_HD:   ncomp_m1 = 2'd0;
      default:              ncomp_m1 = 2'd2;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (nsel_q)
        NS_T:         norm_vec_o[i] = t_q[i];
        NS_N:         norm_vec_o[i] = n_q[i];
        NS_P:         norm_vec_o[i] = pr_q[i];
        default:      norm_vec_o[i] = b_q[i];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      job_q   <= J_DET;
      nsel_q  <= NS_T;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      nsel_q  <= nsel_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    nsel_d       = nsel_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    face_pop_o   = 1'b0;
    norm_start_o = 1'b0;
    res_push_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!face_empty_i) begin
          face_pop_o = 1'b1;
          state_d    = B_DIFF;
        end
      end
      B_DIFF: begin
        job_d   = J_DET;
        i_d     = '0;
        j_d     = '0;
        k_d     = '0;
        state_d = B_MUL;
      end
      B_MUL: begin
        state_d = B_ACC;
      end
      B_ACC: begin
        if (j_q == nterms_m1) begin
          state_d = B_WB;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = B_MUL;
        end
      end
      B_WB: begin
        j_d = '0;
        if (i_q != ncomp_m1) begin
          i_d     = i_q + 2'd1;
          state_d = B_MUL;
        end else begin
          i_d = '0;
          case (job_q)
            J_DET: begin
              if (acc_q == 64'sd0) begin
                k_d     = '0;
                state_d = B_DEGEN;
              end else begin
                job_d   = J_TP;
                state_d = B_MUL;
              end
            end
            J_TP: begin
              job_d   = J_BP;
              state_d = B_MUL;
            end
            J_BP: begin
              nsel_d  = NS_T;
              state_d = B_NORM;
            end
            J_N: begin
              nsel_d  = NS_N;
              state_d = B_NORM;
            end
            J_DOT: begin
              job_d   = J_PERP;
              state_d = B_MUL;
            end
            J_PERP: begin
              nsel_d  = NS_B2;
              state_d = B_NORM;
            end
            J_C: begin
              job_d   = J_HD;
              state_d = B_MUL;
            end
            J_HD: begin
              job_d   = J_PR;
              k_d     = '0;
              state_d = B_MUL;
            end
            J_PR: begin
              nsel_d  = NS_P;
              state_d = B_NORM;
            end
            default: begin
              state_d = B_IDLE;
            end
          endcase
        end
      end
      B_NORM: begin
        norm_start_o = 1'b1;
        state_d      = B_NWAIT;
      end
      B_NWAIT: begin
        if (norm_rsp_i.done) begin
          if (nsel_q == NS_P) begin
            state_d = B_EMIT;
          end else if (!norm_rsp_i.ok) begin
            k_d     = '0;
            state_d = B_DEGEN;
          end else begin
            case (nsel_q)
              NS_T: begin
                nsel_d  = NS_B1;
                state_d = B_NORM;
              end
              NS_B1: begin
                job_d   = J_N;
                state_d = B_MUL;
              end
              NS_N: begin
                state_d = B_FLIP;
              end
              NS_B2: begin
                job_d   = J_C;
                state_d = B_MUL;
              end
              default: begin
                state_d = B_IDLE;
              end
            endcase
          end
        end
      end
      B_FLIP: begin
        job_d   = J_DOT;
        state_d = B_MUL;
      end
      B_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (k_q == 2'd2) begin
            state_d = B_IDLE;
          end else begin
            k_d     = k_q + 2'd1;
            job_d   = J_PR;
            i_d     = '0;
            j_d     = '0;
            state_d = B_MUL;
          end
        end
      end
      B_DEGEN: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (k_q == 2'd2) begin
            state_d = B_IDLE;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!face_empty_i) begin
          rec_q <= face_i;
        end
      end
      B_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= 33'($signed(rec_q.pos[1][i])) - 33'($signed(rec_q.pos[0][i]));
          e2_q[i] <= 33'($signed(rec_q.pos[2][i])) - 33'($signed(rec_q.pos[0][i]));
        end
        du1_q <= 25'($signed(rec_q.uv[1][0])) - 25'($signed(rec_q.uv[0][0]));
        dv1_q <= 25'($signed(rec_q.uv[1][1])) - 25'($signed(rec_q.uv[0][1]));
        du2_q <= 25'($signed(rec_q.uv[2][0])) - 25'($signed(rec_q.uv[0][0]));
        dv2_q <= 25'($signed(rec_q.uv[2][1])) - 25'($signed(rec_q.uv[0][1]));
      end
      B_MUL: begin
        mul_q <= prod[63:0];
      end
      B_ACC: begin
        acc_q <= op_neg ? (acc_base - mul_q) : (acc_base + mul_q);
      end
      B_WB: begin
        case (job_q)
          J_DET:  det_neg_q  <= acc_q[63];
          J_TP:   t_q[i_q]   <= acc_q;
          J_BP:   b_q[i_q]   <= acc_q;
          J_N:    n_q[i_q]   <= acc_q;
          J_DOT:  d30_q      <= $signed(acc_shr[32:0]);
          J_PERP: b_q[i_q]   <= b_q[i_q] - $signed(acc_shr);
          J_C:    c_q[i_q]   <= $signed(acc_shr[32:0]);
          J_HD: begin
            // flip the tangent for a left-handed frame
            if (acc_q[63]) begin
              for (int i = 0; i < 3; i++) begin
                t_q[i] <= -t_q[i];
              end
            end
          end
          J_PR:   pr_q[i_q]  <= acc_q;
          default: begin
          end
        endcase
      end
      B_NWAIT: begin
        if (norm_rsp_i.done) begin
          for (int i = 0; i < 3; i++) begin
            case (nsel_q)
              NS_T:    t_q[i]  <= $signed(norm_res_i[i]);
              NS_N:    n_q[i]  <= $signed(norm_res_i[i]);
              NS_P:    pr_q[i] <= $signed(norm_res_i[i]);
              default: b_q[i]  <= $signed(norm_res_i[i]);
            endcase
          end
          if (nsel_q == NS_P) begin
            good_q <= norm_rsp_i.ok;
          end
        end
      end
      B_FLIP: begin
        if (det_neg_q) begin
          for (int i = 0; i < 3; i++) begin
            t_q[i] <= -t_q[i];
            b_q[i] <= -b_q[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign emit_good = (state_q == B_EMIT) && good_q;

  always_comb begin
    res_o.idx          = rec_q.idx[k_q];
    res_o.tx           = emit_good ? to_q14(pr_q[0]) : '0;
    res_o.ty           = emit_good ? to_q14(pr_q[1]) : '0;
    res_o.tz           = emit_good ? to_q14(pr_q[2]) : '0;
    res_o.degenerate   = !emit_good;
    res_o.last_of_face = (k_q == 2'd2);
    res_o.mesh_done    = (k_q == 2'd2) && rec_q.last;
  end

endmodule

FILE: rtl/tangent_space_normal_transform_top.sv
// Top level of the tangent-space normal transform: front, face queue, back, result queue.
//
//  channel   handshake          payload
//  corners   push / full        pos_x_i..mesh_end_i, one corner per transaction
//  results   pop / empty        out_index_o..mesh_done_o, three per face
//
//  The first two corners of a face are always taken; the third is taken
//  as soon as the face queue has room. Most of the back end's work on a face goes
//  to the normalizer (a shift search of up to 33 steps, a 32-step square root
//  and three 31-step divides), which runs seven times per face; a face found
//  degenerate at the determinant skips it and goes straight to its results.
//  Reset clears all control state; no clearing pass. Results wait in the result
//  queue, and the back end stalls only when that queue is full.
module tangent_space_normal_transform_top #(
  parameter int INDEX_BITS   = 20,
  parameter int FACE_DEPTH   = 2,
  parameter int RESULT_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [tsn_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [tsn_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [tsn_pkg::POS_W-1:0]    pos_z_i,
  input  logic signed [tsn_pkg::UV_W-1:0]     tex_u_i,
  input  logic signed [tsn_pkg::UV_W-1:0]     tex_v_i,
  input  logic signed [tsn_pkg::NRM_W-1:0]    normal_x_i,
  input  logic signed [tsn_pkg::NRM_W-1:0]    normal_y_i,
  input  logic signed [tsn_pkg::NRM_W-1:0]    normal_z_i,
  input  logic [tsn_pkg::IDX_W-1:0]           normal_index_i,
  input  logic                                mesh_end_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [tsn_pkg::IDX_W-1:0]           out_index_o,
  output logic signed [tsn_pkg::TAN_W-1:0]    tan_x_o,
  output logic signed [tsn_pkg::TAN_W-1:0]    tan_y_o,
  output logic signed [tsn_pkg::TAN_W-1:0]    tan_z_o,
  output logic                                degenerate_o,
  output logic                                last_of_face_o,
  output logic                                mesh_done_o
);
  import tsn_pkg::*;

  face_t            face_in, face_out;
  logic             face_push, face_full, face_pop, face_empty;
  result_t          res_in, res_out;
  logic             res_push, res_full;
  logic             norm_start;
  logic [2:0][63:0] norm_vec, norm_res;
  norm_rsp_t        norm_rsp;

  tsn_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .tex_u_i        (tex_u_i),
    .tex_v_i        (tex_v_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .normal_index_i (normal_index_i),
    .mesh_end_i     (mesh_end_i),
    .face_full_i    (face_full),
    .face_push_o    (face_push),
    .face_o         (face_in)
  );

  tsn_fifo #(
    .T_t   (face_t),
    .DEPTH (FACE_DEPTH)
  ) u_face_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (face_push),
    .data_i  (face_in),
    .full_o  (face_full),
    .pop_i   (face_pop),
    .data_o  (face_out),
    .empty_o (face_empty)
  );

  tsn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .rsp_o   (norm_rsp),
    .vec_o   (norm_res)
  );

  tsn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .face_empty_i (face_empty),
    .face_i       (face_out),
    .face_pop_o   (face_pop),
    .norm_start_o (norm_start),
    .norm_vec_o   (norm_vec),
    .norm_rsp_i   (norm_rsp),
    .norm_res_i   (norm_res),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  tsn_fifo #(
    .T_t   (result_t),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_index_o    = res_out.idx;
  assign tan_x_o        = $signed(res_out.tx);
  assign tan_y_o        = $signed(res_out.ty);
  assign tan_z_o        = $signed(res_out.tz);
  assign degenerate_o   = res_out.degenerate;
  assign last_of_face_o = res_out.last_of_face;
  assign mesh_done_o    = res_out.mesh_done;

endmodule
